FILE: hw/rtl/ultrasonic_range_conditioner_assert.svh
// Assertion macros for the ultrasonic range conditioner.
// Expects clk_i and rst_ni in the scope of each use; empty under SYNTHESIS.
`ifndef ULTRASONIC_RANGE_CONDITIONER_ASSERT_SVH
`define ULTRASONIC_RANGE_CONDITIONER_ASSERT_SVH

`ifndef SYNTHESIS

// Check out of reset only.
`define URC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every edge, reset included.
`define URC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define URC_ASSERT(lbl, prop, msg)
`define URC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hw/rtl/urc_pkg.sv
// Shared constants and types for the ultrasonic range conditioner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urc_pkg;

  // Field widths
  localparam int ECHO_BITS = 16;
  localparam int CM_BITS   = 10;   // unsigned distance range 0..1023
  localparam int OUT_BITS  = 11;   // signed result fields
  localparam int HOLD_BITS = 8;
  localparam int GAIN_BITS = 9;
  localparam int GAIN_FRAC = 8;    // gain is Q1.8

  // APB register map
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    REG_MAX_DIST   = 2'd0,
    REG_HOLD_LIMIT = 2'd1,
    REG_MAX_JUMP   = 2'd2,
    REG_GAIN       = 2'd3
  } reg_idx_e;

  localparam logic [CM_BITS-1:0]   MAX_DIST_RST   = 10'd400;
  localparam logic [HOLD_BITS-1:0] HOLD_LIMIT_RST = 8'd3;
  localparam logic [CM_BITS-1:0]   MAX_JUMP_RST   = 10'd50;
  localparam logic [GAIN_BITS-1:0] GAIN_RST       = 9'd77;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE       = 9'd256;

  // floor(x / 58) == (x * RECIP_MUL) >> RECIP_SHIFT for every 16-bit x
  localparam int RECIP_BITS  = 17;
  localparam int RECIP_SHIFT = 22;
  localparam int DIV_PROD_BITS = ECHO_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL = 17'd72316;

  // Rounding offset of the Q1.8 gain product
  localparam int GAIN_ROUND = 128;

  localparam logic signed [OUT_BITS-1:0] CM_NONE = -11'sd1;

endpackage

`default_nettype wire

FILE: hw/rtl/ultrasonic_range_conditioner.sv
// Ultrasonic range conditioner: one echo width per beat in, one conditioned range
// per beat out. Channels are served round robin; each keeps an exponential moving
// average with jump rejection and hold-on-miss. Throughput is one beat per cycle
// while the consumer takes results; an accepted echo beat has its divide by 58
// registered in a stage register, then the per-channel filter update feeds the result
// register. The only stall source is a result held by the consumer. Depends on
// urc_pkg and ultrasonic_range_conditioner_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ultrasonic_range_conditioner_assert.svh"

module ultrasonic_range_conditioner #(
  parameter int CHANNELS  = 3,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // echo input
  input  wire logic                                  echo_valid_i,
  output logic                                       echo_ready_o,
  input  wire logic [urc_pkg::ECHO_BITS-1:0]         echo_us_i,
  // result output
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] channel_o,
  output logic signed [urc_pkg::OUT_BITS-1:0]        raw_cm_o,
  output logic signed [urc_pkg::OUT_BITS-1:0]        distance_cm_o,
  // configuration
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [urc_pkg::ADDR_BITS-1:0]         paddr,
  input  wire logic [urc_pkg::DATA_BITS-1:0]         pwdata,
  output logic [urc_pkg::DATA_BITS-1:0]              prdata,
  output logic                                       pready
);

  localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FW   = urc_pkg::CM_BITS + FRAC_BITS;      // filter word
  localparam int PW   = FW + 1 + urc_pkg::GAIN_BITS + 1;   // gain product
  localparam int DW   = PW - urc_pkg::GAIN_FRAC;           // delta
  localparam int NVW  = FW + 4;                            // unclamped update
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);
  localparam logic [FW-1:0] FILT_MAX = {{urc_pkg::CM_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic [FW:0]   HALF_LSB = (FW + 1)'(1) << (FRAC_BITS - 1);

  // ---------------- configuration registers ----------------
  logic [urc_pkg::CM_BITS-1:0]   max_dist_q;
  logic [urc_pkg::HOLD_BITS-1:0] hold_limit_q;
  logic [urc_pkg::CM_BITS-1:0]   max_jump_q;
  logic [urc_pkg::GAIN_BITS-1:0] gain_q;
  urc_pkg::reg_idx_e             reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = urc_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q   <= urc_pkg::MAX_DIST_RST;
      hold_limit_q <= urc_pkg::HOLD_LIMIT_RST;
      max_jump_q   <= urc_pkg::MAX_JUMP_RST;
      gain_q       <= urc_pkg::GAIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        urc_pkg::REG_MAX_DIST:   max_dist_q   <= pwdata[urc_pkg::CM_BITS-1:0];
        urc_pkg::REG_HOLD_LIMIT: hold_limit_q <= pwdata[urc_pkg::HOLD_BITS-1:0];
        urc_pkg::REG_MAX_JUMP:   max_jump_q   <= pwdata[urc_pkg::CM_BITS-1:0];
        urc_pkg::REG_GAIN:       gain_q       <= pwdata[urc_pkg::GAIN_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      urc_pkg::REG_MAX_DIST:   prdata = urc_pkg::DATA_BITS'(max_dist_q);
      urc_pkg::REG_HOLD_LIMIT: prdata = urc_pkg::DATA_BITS'(hold_limit_q);
      urc_pkg::REG_MAX_JUMP:   prdata = urc_pkg::DATA_BITS'(max_jump_q);
      urc_pkg::REG_GAIN:       prdata = urc_pkg::DATA_BITS'(gain_q);
    endcase
  end

  // ---------------- handshake ----------------
  logic out_valid_q;
  logic s1_valid_q;
  logic out_free;
  logic in_fire;
  logic s2_fire;

  assign out_free     = !out_valid_q || out_ready_i;
  assign echo_ready_o = !s1_valid_q || out_free;
  assign in_fire      = echo_valid_i && echo_ready_o;
  assign s2_fire      = s1_valid_q && out_free;

  // ---------------- stage 1: channel tag and divide by 58 ----------------
  logic [CW-1:0]                      next_ch_q;
  logic [CW-1:0]                      s1_ch_q;
  logic [urc_pkg::OUT_BITS-1:0]       s1_raw_q;
  logic [urc_pkg::DIV_PROD_BITS-1:0]  div_prod;

  assign div_prod = urc_pkg::DIV_PROD_BITS'(echo_us_i) *
                    urc_pkg::DIV_PROD_BITS'(urc_pkg::RECIP_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_ch_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (echo_ready_o) begin
        s1_valid_q <= echo_valid_i;
      end
      if (in_fire) begin
        next_ch_q <= (next_ch_q == LAST_CH) ? '0 : next_ch_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q  <= next_ch_q;
      s1_raw_q <= div_prod[urc_pkg::RECIP_SHIFT +: urc_pkg::OUT_BITS];
    end
  end

  // ---------------- stage 2: per-channel filter update ----------------
  logic [FW-1:0]                 filt_q  [CHANNELS];
  logic                          fv_q    [CHANNELS];
  logic [urc_pkg::HOLD_BITS-1:0] miss_q  [CHANNELS];

  logic [FW-1:0]                 cur_filt;
  logic                          cur_fv;
  logic [urc_pkg::HOLD_BITS-1:0] cur_miss;
  logic                          cm_valid;
  logic [FW-1:0]                 target;
  logic signed [FW:0]            diff;
  logic signed [FW:0]            neg_diff;
  logic [FW-1:0]                 mag;
  logic [FW-1:0]                 jump_lim;
  logic [urc_pkg::GAIN_BITS-1:0] gain_eff;
  logic signed [PW-1:0]          prod;
  logic signed [DW-1:0]          delta;
  logic signed [NVW-1:0]         nv;
  logic [FW-1:0]                 upd_filt;
  logic [FW-1:0]                 filt_d;
  logic                          fv_d;
  logic [urc_pkg::HOLD_BITS-1:0] miss_d;
  logic                          none_d;
  logic [FW:0]                   round_sum;
  logic signed [urc_pkg::OUT_BITS-1:0] dist_d;
  logic signed [urc_pkg::OUT_BITS-1:0] raw_d;

  assign cur_filt = filt_q[s1_ch_q];
  assign cur_fv   = fv_q[s1_ch_q];
  assign cur_miss = miss_q[s1_ch_q];

  assign cm_valid = (s1_raw_q != '0) &&
                    (s1_raw_q <= {1'b0, max_dist_q});
  assign target   = {s1_raw_q[urc_pkg::CM_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign diff     = $signed({1'b0, target}) - $signed({1'b0, cur_filt});
  assign neg_diff = -diff;
  assign mag      = diff[FW] ? neg_diff[FW-1:0] : diff[FW-1:0];
  assign jump_lim = {max_jump_q, {FRAC_BITS{1'b0}}};
  assign gain_eff = (gain_q > urc_pkg::GAIN_ONE) ? urc_pkg::GAIN_ONE : gain_q;

  // Round the Q1.8 product half up, then floor (arithmetic shift)
  assign prod  = PW'(diff) * $signed({1'b0, gain_eff}) + PW'(urc_pkg::GAIN_ROUND);
  assign delta = prod[PW-1:urc_pkg::GAIN_FRAC];
  assign nv    = $signed(NVW'({1'b0, cur_filt})) + NVW'(delta);

  always_comb begin
    if (nv[NVW-1]) begin
      upd_filt = '0;
    end else if (nv > $signed(NVW'(FILT_MAX))) begin
      upd_filt = FILT_MAX;
    end else begin
      upd_filt = nv[FW-1:0];
    end
  end

  always_comb begin
    filt_d = cur_filt;
    fv_d   = cur_fv;
    miss_d = cur_miss;
    none_d = 1'b0;
    if (!cm_valid) begin
      // bridge the miss while the hold budget lasts, else drop the channel
      if (cur_fv && (cur_miss < hold_limit_q)) begin
        miss_d = cur_miss + urc_pkg::HOLD_BITS'(1);
      end else begin
        fv_d   = 1'b0;
        none_d = 1'b1;
      end
    end else begin
      miss_d = '0;
      if (!cur_fv) begin
        filt_d = target;
        fv_d   = 1'b1;
      end else if (mag <= jump_lim) begin
        filt_d = upd_filt;
      end
    end
  end

  assign round_sum = {1'b0, filt_d} + HALF_LSB;
  assign dist_d    = none_d ? urc_pkg::CM_NONE
                            : $signed(round_sum[FW:FRAC_BITS]);
  assign raw_d     = cm_valid ? $signed(s1_raw_q) : urc_pkg::CM_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        filt_q[c] <= '0;
        fv_q[c]   <= 1'b0;
        miss_q[c] <= '0;
      end
    end else if (s2_fire) begin
      filt_q[s1_ch_q] <= filt_d;
      fv_q[s1_ch_q]   <= fv_d;
      miss_q[s1_ch_q] <= miss_d;
    end
  end

  // ---------------- result register ----------------
  logic [CW-1:0]                       channel_q;
  logic signed [urc_pkg::OUT_BITS-1:0] raw_q;
  logic signed [urc_pkg::OUT_BITS-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      channel_q <= s1_ch_q;
      raw_q     <= raw_d;
      dist_q    <= dist_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_o     = channel_q;
  assign raw_cm_o      = raw_q;
  assign distance_cm_o = dist_q;

  // ---------------- assertions ----------------
  `URC_ASSERT(a_valid_raw_has_distance,
    out_valid_q && (raw_q != urc_pkg::CM_NONE) |-> (dist_q != urc_pkg::CM_NONE),
    "valid reading produced no filtered distance")
  `URC_ASSERT(a_channel_in_range,
    out_valid_q |-> (channel_q <= LAST_CH),
    "result channel out of range")
  `URC_ASSERT(a_filter_bounded,
    s1_valid_q && fv_q[s1_ch_q] |-> (filt_q[s1_ch_q] <= FILT_MAX),
    "filter state above full scale")
  `URC_ASSERT(a_stage_drains,
    s2_fire |=> out_valid_q,
    "stage beat lost on the way to the result register")

endmodule

`default_nettype wire
